// File: hw/rtl/gplru_pkg.sv
// ----------------------------------------------------------------------------
// Group peer LRU table package
// Sizes, codes, state and command types shared by the table's modules.
// ----------------------------------------------------------------------------
package gplru_pkg;

   localparam int MAX_FABRIC_SLOTS  = 8;
   localparam int MAX_DATA_PEERS    = 16;
   localparam int MAX_CONTROL_PEERS = 4;

   localparam int SLOT_W  = (MAX_FABRIC_SLOTS > 1) ? $clog2(MAX_FABRIC_SLOTS) : 1;
   localparam int DCNT_W  = $clog2(MAX_DATA_PEERS + 1);
   localparam int CCNT_W  = $clog2(MAX_CONTROL_PEERS + 1);
   localparam int KMAX    = (MAX_DATA_PEERS > MAX_CONTROL_PEERS) ?
                            MAX_DATA_PEERS : MAX_CONTROL_PEERS;
   localparam int IDX_W   = $clog2(KMAX + 1);
   localparam int DDEPTH  = MAX_FABRIC_SLOTS * MAX_DATA_PEERS;
   localparam int CDEPTH  = MAX_FABRIC_SLOTS * MAX_CONTROL_PEERS;
   localparam int DADDR_W = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
   localparam int CADDR_W = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

   localparam logic [1:0] KIND_FIND_OR_ADD   = 2'd0;
   localparam logic [1:0] KIND_REMOVE_PEER   = 2'd1;
   localparam logic [1:0] KIND_REMOVE_FABRIC = 2'd2;
   localparam logic [1:0] KIND_RESERVED      = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_NO_SLOT   = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_DISPATCH, S_FRESH, S_SRD, S_SCMP, S_SHR_RD, S_SHR_WR,
      S_FRONT, S_SHL_RD, S_SHL_WR, S_FREE, S_COPY, S_DONE
   } state_type;

   typedef enum logic [2:0] {RD_NONE, RD_IDX, RD_IDX_M1, RD_IDX_P1, RD_COPY} rd_op_type;
   typedef enum logic [1:0] {WR_NONE, WR_IDX, WR_FRONT, WR_COPY} wr_op_type;
   typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_COUNT} idx_op_type;
   typedef enum logic [2:0] {
      TBL_NONE, TBL_FRESH, TBL_CNT_INC, TBL_CNT_DEC, TBL_CLEAR, TBL_MOVE
   } tbl_op_type;

   typedef struct packed {
      logic       req_ready;
      logic       load;
      logic       slot_load;
      rd_op_type  rd;
      wr_op_type  wr;
      idx_op_type idx;
      tbl_op_type tbl;
      logic       res_status_en;
      logic [1:0] res_status;
      logic       res_slot;
      logic       res_new;
      logic       res_evict;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic       invalid;
      logic [1:0] kind;
      logic       hit;
      logic       free_avail;
      logic       cnt_zero;
      logic       cnt_full;
      logic       idx_zero;
      logic       idx_last;
      logic       shl_done;
      logic       node_eq;
      logic       last_peer;
      logic       slot_last;
      logic       copy_done;
      logic       out_free;
   } stat_type;

endpackage

// File: hw/rtl/gplru_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table request word.
// ----------------------------------------------------------------------------
interface gplru_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  fabric_id;
   logic [63:0] node_id;
   logic        is_control;

   modport source (output valid, kind, fabric_id, node_id, is_control, input ready);
   modport sink   (input valid, kind, fabric_id, node_id, is_control, output ready);
endinterface

// File: hw/rtl/gplru_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one table response word.
// ----------------------------------------------------------------------------
interface gplru_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [2:0]  fabric_slot;
   logic        is_new;
   logic        evicted;
   logic [63:0] evicted_node;

   modport source (output valid, status, fabric_slot, is_new, evicted, evicted_node,
                   input ready);
   modport sink   (input valid, status, fabric_slot, is_new, evicted, evicted_node,
                   output ready);
endinterface

// File: hw/rtl/gplru_ctrl.sv
// ----------------------------------------------------------------------------
// Group peer LRU table controller
// Sequences lookup, list search, shifts and slot compaction.
// ----------------------------------------------------------------------------
module gplru_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  gplru_pkg::stat_type stat,
   output gplru_pkg::cmd_type  cmd
);
   import gplru_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.rd            = RD_NONE;
      cmd.wr            = WR_NONE;
      cmd.idx           = IDX_HOLD;
      cmd.tbl           = TBL_NONE;
      cmd.res_status    = ST_OK;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (stat.req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.invalid) begin
               cmd.res_status_en = 1'b1;
               cmd.res_status    = ST_INVALID;
               state_in          = S_DONE;
            end else begin
               cmd.slot_load = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.kind)
               KIND_FIND_OR_ADD: begin
                  if (stat.hit) begin
                     cmd.idx = IDX_ZERO;
                     if (stat.cnt_zero) begin
                        cmd.res_new = 1'b1;
                        cmd.tbl     = TBL_CNT_INC;
                        state_in    = S_FRONT;
                     end else begin
                        state_in = S_SRD;
                     end
                  end else if (stat.free_avail) begin
                     state_in = S_FRESH;
                  end else begin
                     cmd.res_status_en = 1'b1;
                     cmd.res_status    = ST_NO_SLOT;
                     state_in          = S_DONE;
                  end
               end
               KIND_REMOVE_PEER: begin
                  if (stat.hit && !stat.cnt_zero) begin
                     cmd.idx  = IDX_ZERO;
                     state_in = S_SRD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               KIND_REMOVE_FABRIC: begin
                  state_in = stat.hit ? S_FREE : S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FRESH: begin
            cmd.tbl           = TBL_FRESH;
            cmd.wr            = WR_FRONT;
            cmd.res_status_en = 1'b1;
            cmd.res_slot      = 1'b1;
            cmd.res_new       = 1'b1;
            state_in          = S_DONE;
         end
         S_SRD: begin
            cmd.rd   = RD_IDX;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (stat.node_eq) begin
               state_in = (stat.kind == KIND_FIND_OR_ADD) ? S_SHR_RD : S_SHL_RD;
            end else if (stat.idx_last) begin
               if (stat.kind == KIND_FIND_OR_ADD) begin
                  cmd.res_new = 1'b1;
                  if (stat.cnt_full) begin
                     cmd.res_evict = 1'b1;
                  end else begin
                     cmd.tbl = TBL_CNT_INC;
                     cmd.idx = IDX_COUNT;
                  end
                  state_in = S_SHR_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cmd.idx  = IDX_INC;
               state_in = S_SRD;
            end
         end
         S_SHR_RD: begin
            if (stat.idx_zero) begin
               state_in = S_FRONT;
            end else begin
               cmd.rd   = RD_IDX_M1;
               state_in = S_SHR_WR;
            end
         end
         S_SHR_WR: begin
            cmd.wr   = WR_IDX;
            cmd.idx  = IDX_DEC;
            state_in = S_SHR_RD;
         end
         S_FRONT: begin
            cmd.wr            = WR_FRONT;
            cmd.res_status_en = 1'b1;
            cmd.res_slot      = 1'b1;
            state_in          = S_DONE;
         end
         S_SHL_RD: begin
            if (stat.shl_done) begin
               cmd.tbl           = TBL_CNT_DEC;
               cmd.res_status_en = 1'b1;
               cmd.res_slot      = 1'b1;
               state_in          = stat.last_peer ? S_FREE : S_DONE;
            end else begin
               cmd.rd   = RD_IDX_P1;
               state_in = S_SHL_WR;
            end
         end
         S_SHL_WR: begin
            cmd.wr   = WR_IDX;
            cmd.idx  = IDX_INC;
            state_in = S_SHL_RD;
         end
         S_FREE: begin
            cmd.res_status_en = 1'b1;
            cmd.res_slot      = 1'b1;
            if (stat.slot_last) begin
               cmd.tbl  = TBL_CLEAR;
               state_in = S_DONE;
            end else begin
               cmd.tbl  = TBL_MOVE;
               cmd.idx  = IDX_ZERO;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            cmd.rd = RD_COPY;
            if (!stat.idx_zero) begin
               cmd.wr = WR_COPY;
            end
            if (stat.copy_done) begin
               state_in = S_DONE;
            end else begin
               cmd.idx = IDX_INC;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/gplru_dp.sv
// ----------------------------------------------------------------------------
// Group peer LRU table datapath
// Fabric id and count registers, node list memories, result and output words.
// ----------------------------------------------------------------------------
module gplru_dp (
   input  logic                clock,
   input  logic                reset,
   input  gplru_pkg::cmd_type  cmd,
   output gplru_pkg::stat_type stat,
   gplru_req_if.sink           req_ch,
   gplru_rsp_if.source         rsp_ch
);
   import gplru_pkg::*;

   logic [1:0]        kind_ff;
   logic [7:0]        fab_ff;
   logic [63:0]       node_ff;
   logic              ctl_ff;

   logic [7:0]        ids_ff  [MAX_FABRIC_SLOTS];
   logic [DCNT_W-1:0] dcnt_ff [MAX_FABRIC_SLOTS];
   logic [CCNT_W-1:0] ccnt_ff [MAX_FABRIC_SLOTS];

   logic [SLOT_W-1:0] cur_ff, src_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [1:0]        res_status_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              res_new_ff, res_ev_ff;
   logic [63:0]       res_evnode_ff;

   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_status_ff;
   logic [SLOT_W-1:0] out_slot_ff;
   logic              out_new_ff, out_ev_ff;
   logic [63:0]       out_evnode_ff;

   logic [63:0]       data_mem [DDEPTH];
   logic [63:0]       ctl_mem  [CDEPTH];
   logic [63:0]       drd_ff, crd_ff;

   logic              hit, free_avail;
   logic [SLOT_W-1:0] hit_slot, free_slot, used_last;
   logic [IDX_W-1:0]  n_sel, n_other, cap_sel, idx_m1, idx_p1, rd_idx;
   logic [IDX_W:0]    idx_next;
   logic [63:0]       rdata_sel;

   logic               d_re, c_re, d_we, c_we;
   logic [DADDR_W-1:0] d_ra, d_wa;
   logic [CADDR_W-1:0] c_ra, c_wa;
   logic [63:0]        d_wd, c_wd;

   function automatic logic [DADDR_W-1:0] daddr(input logic [SLOT_W-1:0] s,
                                               input logic [IDX_W-1:0] i);
      return DADDR_W'(int'(s) * MAX_DATA_PEERS + int'(i));
   endfunction

   function automatic logic [CADDR_W-1:0] caddr(input logic [SLOT_W-1:0] s,
                                               input logic [IDX_W-1:0] i);
      return CADDR_W'(int'(s) * MAX_CONTROL_PEERS + int'(i));
   endfunction

   // Used slots are packed at the front, so the first free slot marks the end.
   always_comb begin
      hit        = 1'b0;
      hit_slot   = '0;
      free_avail = 1'b0;
      free_slot  = '0;
      for (int s = MAX_FABRIC_SLOTS - 1; s >= 0; s--) begin
         if (ids_ff[s] == fab_ff) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(s);
         end
         if (ids_ff[s] == 8'd0) begin
            free_avail = 1'b1;
            free_slot  = SLOT_W'(s);
         end
      end
      used_last = free_avail ? free_slot - 1'b1 : SLOT_W'(MAX_FABRIC_SLOTS - 1);
   end

   assign n_sel     = ctl_ff ? IDX_W'(ccnt_ff[cur_ff]) : IDX_W'(dcnt_ff[cur_ff]);
   assign n_other   = ctl_ff ? IDX_W'(dcnt_ff[cur_ff]) : IDX_W'(ccnt_ff[cur_ff]);
   assign cap_sel   = ctl_ff ? IDX_W'(MAX_CONTROL_PEERS) : IDX_W'(MAX_DATA_PEERS);
   assign rdata_sel = ctl_ff ? crd_ff : drd_ff;
   assign idx_m1    = idx_ff - 1'b1;
   assign idx_p1    = idx_ff + 1'b1;
   assign idx_next  = {1'b0, idx_ff} + 1'b1;

   always_comb begin
      stat            = '0;
      stat.req_valid  = req_ch.valid;
      stat.invalid    = (kind_ff == KIND_RESERVED) || (fab_ff == 8'd0) ||
                        ((kind_ff != KIND_REMOVE_FABRIC) && (node_ff == 64'd0));
      stat.kind       = kind_ff;
      stat.hit        = hit;
      stat.free_avail = free_avail;
      stat.cnt_zero   = (n_sel == '0);
      stat.cnt_full   = (n_sel == cap_sel);
      stat.idx_zero   = (idx_ff == '0);
      stat.idx_last   = (idx_next == {1'b0, n_sel});
      stat.shl_done   = (idx_next >= {1'b0, n_sel});
      stat.node_eq    = (rdata_sel == node_ff);
      stat.last_peer  = (n_sel == IDX_W'(1)) && (n_other == '0);
      stat.slot_last  = (cur_ff == used_last);
      stat.copy_done  = (idx_ff == IDX_W'(KMAX));
      stat.out_free   = !out_valid_ff || rsp_ch.ready;
   end

   // Request word and working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_ch.kind;
         fab_ff  <= req_ch.fabric_id;
         node_ff <= req_ch.node_id;
         ctl_ff  <= req_ch.is_control;
      end
      if (cmd.slot_load) begin
         cur_ff <= hit ? hit_slot : free_slot;
      end
      if (cmd.tbl == TBL_MOVE) begin
         src_ff <= used_last;
      end
      idx_ff <= idx_in;
   end

   always_comb begin
      case (cmd.idx)
         IDX_ZERO:  idx_in = '0;
         IDX_INC:   idx_in = idx_p1;
         IDX_DEC:   idx_in = idx_m1;
         IDX_COUNT: idx_in = n_sel;
         default:   idx_in = idx_ff;
      endcase
   end

   // Fabric ids and list counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_FABRIC_SLOTS; s++) begin
            ids_ff[s]  <= 8'd0;
            dcnt_ff[s] <= '0;
            ccnt_ff[s] <= '0;
         end
      end else begin
         case (cmd.tbl)
            TBL_FRESH: begin
               ids_ff[cur_ff]  <= fab_ff;
               dcnt_ff[cur_ff] <= ctl_ff ? DCNT_W'(0) : DCNT_W'(1);
               ccnt_ff[cur_ff] <= ctl_ff ? CCNT_W'(1) : CCNT_W'(0);
            end
            TBL_CNT_INC: begin
               if (ctl_ff) begin
                  ccnt_ff[cur_ff] <= ccnt_ff[cur_ff] + 1'b1;
               end else begin
                  dcnt_ff[cur_ff] <= dcnt_ff[cur_ff] + 1'b1;
               end
            end
            TBL_CNT_DEC: begin
               if (ctl_ff) begin
                  ccnt_ff[cur_ff] <= ccnt_ff[cur_ff] - 1'b1;
               end else begin
                  dcnt_ff[cur_ff] <= dcnt_ff[cur_ff] - 1'b1;
               end
            end
            TBL_CLEAR: begin
               ids_ff[cur_ff]  <= 8'd0;
               dcnt_ff[cur_ff] <= '0;
               ccnt_ff[cur_ff] <= '0;
            end
            TBL_MOVE: begin
               ids_ff[cur_ff]     <= ids_ff[used_last];
               dcnt_ff[cur_ff]    <= dcnt_ff[used_last];
               ccnt_ff[cur_ff]    <= ccnt_ff[used_last];
               ids_ff[used_last]  <= 8'd0;
               dcnt_ff[used_last] <= '0;
               ccnt_ff[used_last] <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Memory port selection.
   always_comb begin
      case (cmd.rd)
         RD_IDX_M1: rd_idx = idx_m1;
         RD_IDX_P1: rd_idx = idx_p1;
         default:   rd_idx = idx_ff;
      endcase
      d_re = 1'b0;
      c_re = 1'b0;
      d_ra = daddr(cur_ff, rd_idx);
      c_ra = caddr(cur_ff, rd_idx);
      d_we = 1'b0;
      c_we = 1'b0;
      d_wa = daddr(cur_ff, idx_ff);
      c_wa = caddr(cur_ff, idx_ff);
      d_wd = rdata_sel;
      c_wd = rdata_sel;
      case (cmd.rd)
         RD_IDX, RD_IDX_M1, RD_IDX_P1: begin
            c_re = ctl_ff;
            d_re = !ctl_ff;
         end
         RD_COPY: begin
            d_re = idx_ff < IDX_W'(MAX_DATA_PEERS);
            c_re = idx_ff < IDX_W'(MAX_CONTROL_PEERS);
            d_ra = daddr(src_ff, idx_ff);
            c_ra = caddr(src_ff, idx_ff);
         end
         default: begin
         end
      endcase
      case (cmd.wr)
         WR_IDX: begin
            c_we = ctl_ff;
            d_we = !ctl_ff;
         end
         WR_FRONT: begin
            c_we = ctl_ff;
            d_we = !ctl_ff;
            d_wa = daddr(cur_ff, '0);
            c_wa = caddr(cur_ff, '0);
            d_wd = node_ff;
            c_wd = node_ff;
         end
         WR_COPY: begin
            d_we = idx_m1 < IDX_W'(MAX_DATA_PEERS);
            c_we = idx_m1 < IDX_W'(MAX_CONTROL_PEERS);
            d_wa = daddr(cur_ff, idx_m1);
            c_wa = caddr(cur_ff, idx_m1);
            d_wd = drd_ff;
            c_wd = crd_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         data_mem[d_wa] <= d_wd;
      end
      if (d_re) begin
         drd_ff <= data_mem[d_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         ctl_mem[c_wa] <= c_wd;
      end
      if (c_re) begin
         crd_ff <= ctl_mem[c_ra];
      end
   end

   // Result being built for the current request.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff <= ST_NOT_FOUND;
         res_slot_ff   <= '0;
         res_new_ff    <= 1'b0;
         res_ev_ff     <= 1'b0;
         res_evnode_ff <= 64'd0;
      end else begin
         if (cmd.res_status_en) begin
            res_status_ff <= cmd.res_status;
         end
         if (cmd.res_slot) begin
            res_slot_ff <= cur_ff;
         end
         if (cmd.res_new) begin
            res_new_ff <= 1'b1;
         end
         if (cmd.res_evict) begin
            res_ev_ff     <= 1'b1;
            res_evnode_ff <= rdata_sel;
         end
      end
   end

   // Output register: holds a finished word while the next request is taken.
   assign out_valid_in = cmd.push || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= res_slot_ff;
         out_new_ff    <= res_new_ff;
         out_ev_ff     <= res_ev_ff;
         out_evnode_ff <= res_evnode_ff;
      end
   end

   assign req_ch.ready        = cmd.req_ready;
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.fabric_slot  = 3'(out_slot_ff);
   assign rsp_ch.is_new       = out_new_ff;
   assign rsp_ch.evicted      = out_ev_ff;
   assign rsp_ch.evicted_node = out_evnode_ff;

endmodule

// File: hw/rtl/group_peer_lru_table.sv
// ----------------------------------------------------------------------------
// Group peer LRU table
// Per-fabric move-to-front lists of control and data peer node ids.
// ----------------------------------------------------------------------------
// Usage: requests arrive as words on req_ch (valid/ready). Each word is a
// find_or_add, remove_peer or remove_fabric request and produces exactly one
// response word on rsp_ch (valid/ready), in request order.
// The block works on one request at a time. A request passes through
// lookup and bookkeeping states plus a read state and a compare or write
// state for each list entry searched or shifted, since each list lives in a
// memory with a registered read. Freeing a slot that is not the last used
// one adds a copy sweep that moves the last used slot's lists into it.
// Reset empties the table at once: fabric ids and list counts are flip-flops;
// list memories are never cleared; entries past a count are never searched or returned.
// A finished response word waits in an output register, so a stalled
// receiver does not block acceptance of the next request; that request's
// response is held back until the output register is free.
// ----------------------------------------------------------------------------
module group_peer_lru_table (
   input logic         clock,
   input logic         reset,
   gplru_req_if.sink   req_ch,
   gplru_rsp_if.source rsp_ch
);
   import gplru_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences each request; the datapath holds the table and request state.
   gplru_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   gplru_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// File: sim/gplru_tb_ifs.sv
// ----------------------------------------------------------------------------
// Test channel notes
// The request and response channel interfaces come from the RTL tree; this
// file only holds a constant used by the testbench.
// ----------------------------------------------------------------------------
package gplru_tb_pkg;
   localparam int RSP_LATENCY = 100;
endpackage

// File: sim/group_peer_lru_table_tb.sv
// ----------------------------------------------------------------------------
// Group peer LRU table testbench
// Drives find_or_add, remove_peer, remove_fabric and reserved-kind words into the table,
// predicts each response word from a private copy of the slot table and
// compares every response field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module group_peer_lru_table_tb;
   import gplru_pkg::*;

   // One expected response word.
   typedef struct {
      logic [1:0]  status;
      logic [2:0]  fabric_slot;
      logic        is_new;
      logic        evicted;
      logic [63:0] evicted_node;
   } rsp_word_t;

   // Scoreboard: holds a shadow of the slot table and the queue of
   // response words still to come.
   class lru_scoreboard;
      logic [7:0]  fab_ids [MAX_FABRIC_SLOTS];
      logic [63:0] dnodes  [MAX_FABRIC_SLOTS][MAX_DATA_PEERS];
      logic [63:0] cnodes  [MAX_FABRIC_SLOTS][MAX_CONTROL_PEERS];
      int          dcnt    [MAX_FABRIC_SLOTS];
      int          ccnt    [MAX_FABRIC_SLOTS];
      rsp_word_t   pending_rsp[$];
      int          errors;
      int          checked;
      int          evictions;
      int          hits;

      function void clear_slot(int s);
         fab_ids[s] = 0;
         dcnt[s] = 0;
         ccnt[s] = 0;
         for (int i = 0; i < MAX_DATA_PEERS; i++) dnodes[s][i] = 0;
         for (int i = 0; i < MAX_CONTROL_PEERS; i++) cnodes[s][i] = 0;
      endfunction

      function void reset_table();
         for (int s = 0; s < MAX_FABRIC_SLOTS; s++) clear_slot(s);
         pending_rsp.delete();
         errors = 0;
         checked = 0;
         evictions = 0;
         hits = 0;
      endfunction

      // The last used slot moves down into the freed one.
      function void free_slot(int s);
         clear_slot(s);
         for (int i = MAX_FABRIC_SLOTS - 1; i > s; i--) begin
            if (fab_ids[i] != 0) begin
               fab_ids[s] = fab_ids[i];
               dcnt[s] = dcnt[i];
               ccnt[s] = ccnt[i];
               dnodes[s] = dnodes[i];
               cnodes[s] = cnodes[i];
               clear_slot(i);
               break;
            end
         end
      endfunction

      function int used_slots();
         int n;
         n = 0;
         for (int s = 0; s < MAX_FABRIC_SLOTS; s++) if (fab_ids[s] != 0) n++;
         return n;
      endfunction

      // Move-to-front on one list of one slot; ctl picks the list.
      function void touch_list(int s, bit ctl, logic [63:0] node, ref rsp_word_t r);
         int cap, n, pos;
         logic [63:0] lst [MAX_DATA_PEERS];
         cap = ctl ? MAX_CONTROL_PEERS : MAX_DATA_PEERS;
         n = ctl ? ccnt[s] : dcnt[s];
         for (int i = 0; i < cap; i++) lst[i] = ctl ? cnodes[s][i] : dnodes[s][i];
         pos = cap;
         for (int i = 0; i < n; i++) begin
            if (lst[i] == node) begin
               pos = i;
               break;
            end
         end
         if (pos == cap) begin
            r.is_new = 1'b1;
            if (n < cap) n++;
            else begin
               r.evicted = 1'b1;
               r.evicted_node = lst[cap - 1];
            end
            pos = n - 1;
         end else hits++;
         for (int j = pos; j > 0; j--) lst[j] = lst[j - 1];
         lst[0] = node;
         for (int i = 0; i < cap; i++) begin
            if (ctl) cnodes[s][i] = lst[i];
            else dnodes[s][i] = lst[i];
         end
         if (ctl) ccnt[s] = n;
         else dcnt[s] = n;
      endfunction

      function bit drop_node(int s, bit ctl, logic [63:0] node);
         int cap, n;
         logic [63:0] lst [MAX_DATA_PEERS];
         cap = ctl ? MAX_CONTROL_PEERS : MAX_DATA_PEERS;
         n = ctl ? ccnt[s] : dcnt[s];
         for (int i = 0; i < cap; i++) lst[i] = ctl ? cnodes[s][i] : dnodes[s][i];
         for (int i = 0; i < n; i++) begin
            if (lst[i] == node) begin
               for (int j = i; j + 1 < n; j++) lst[j] = lst[j + 1];
               lst[n - 1] = 0;
               for (int k = 0; k < cap; k++) begin
                  if (ctl) cnodes[s][k] = lst[k];
                  else dnodes[s][k] = lst[k];
               end
               if (ctl) ccnt[s] = n - 1;
               else dcnt[s] = n - 1;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Notes an accepted request word and queues its response word.
      function void note_request(logic [1:0] kind, logic [7:0] fab, logic [63:0] node,
                                 logic ctl);
         rsp_word_t r;
         r = '{ST_NOT_FOUND, 3'd0, 1'b0, 1'b0, 64'd0};
         if (kind == KIND_RESERVED || fab == 0 ||
             (kind != KIND_REMOVE_FABRIC && node == 0)) begin
            r.status = ST_INVALID;
         end else if (kind == KIND_FIND_OR_ADD) begin
            r.status = ST_NO_SLOT;
            for (int s = 0; s < MAX_FABRIC_SLOTS; s++) begin
               if (fab_ids[s] == 0) begin
                  clear_slot(s);
                  fab_ids[s] = fab;
                  if (ctl) begin
                     cnodes[s][0] = node;
                     ccnt[s] = 1;
                  end else begin
                     dnodes[s][0] = node;
                     dcnt[s] = 1;
                  end
                  r.is_new = 1'b1;
                  r.status = ST_OK;
                  r.fabric_slot = 3'(s);
                  break;
               end
               if (fab_ids[s] == fab) begin
                  touch_list(s, ctl, node, r);
                  r.status = ST_OK;
                  r.fabric_slot = 3'(s);
                  break;
               end
            end
         end else begin
            for (int s = 0; s < MAX_FABRIC_SLOTS; s++) begin
               if (fab_ids[s] == fab) begin
                  if (kind == KIND_REMOVE_FABRIC) begin
                     free_slot(s);
                     r.status = ST_OK;
                     r.fabric_slot = 3'(s);
                  end else if (drop_node(s, ctl, node)) begin
                     r.status = ST_OK;
                     r.fabric_slot = 3'(s);
                     if (dcnt[s] == 0 && ccnt[s] == 0) free_slot(s);
                  end
                  break;
               end
            end
         end
         if (r.evicted) evictions++;
         pending_rsp.push_back(r);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("MISMATCH word %0d: %s got %0h expected %0h", checked, what, got, want);
      endtask

      // Checks one accepted response word against the oldest expectation.
      task check_response(rsp_word_t got);
         rsp_word_t want;
         if (pending_rsp.size() == 0) begin
            report("unexpected response", 64'd0, 64'd0);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.status !== want.status)
            report("status", 64'(got.status), 64'(want.status));
         if (got.fabric_slot !== want.fabric_slot)
            report("fabric_slot", 64'(got.fabric_slot), 64'(want.fabric_slot));
         if (got.is_new !== want.is_new)
            report("is_new", 64'(got.is_new), 64'(want.is_new));
         if (got.evicted !== want.evicted)
            report("evicted", 64'(got.evicted), 64'(want.evicted));
         if (got.evicted_node !== want.evicted_node)
            report("evicted_node", got.evicted_node, want.evicted_node);
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   gplru_req_if req_ch ();
   gplru_rsp_if rsp_ch ();

   group_peer_lru_table uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   lru_scoreboard sb;
   int  cycle_count;
   int  sent_words;
   bit  idle_on;       // random idling enabled on both sides
   int  hold_rsp;      // receiver hold-off counted down in cycles
   bit  stim_done;
   localparam int CYCLE_LIMIT = 600000;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      sb = new();
      sb.reset_table();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_FIND_OR_ADD;
      req_ch.fabric_id = 8'd0;
      req_ch.node_id = 64'd0;
      req_ch.is_control = 1'b0;
      rsp_ch.ready = 1'b0;
      idle_on = 1'b0;
      hold_rsp = 0;
      stim_done = 1'b0;
      cycle_count = 0;
      sent_words = 0;
   end

   // Watchdog; the cycle counter bounds the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: when idling is enabled, ready is drawn low with odds of 29 in 100,
   // and it stays low for the whole of a hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_rsp > 0) begin
         hold_rsp <= hold_rsp - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(idle_on && $urandom_range(99) < 29);
      end
   end

   // Responses are checked on the edge at which they are accepted.
   always @(posedge clock) begin
      rsp_word_t got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = rsp_ch.status;
         got.fabric_slot = rsp_ch.fabric_slot;
         got.is_new = rsp_ch.is_new;
         got.evicted = rsp_ch.evicted;
         got.evicted_node = rsp_ch.evicted_node;
         sb.check_response(got);
      end
   end

   // Offers one request word and holds it until the block takes it. The
   // prediction is made on the accepting edge, in request order.
   task automatic send_word(logic [1:0] kind, logic [7:0] fab, logic [63:0] node,
                            logic ctl);
      while (idle_on && $urandom_range(99) < 29) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.fabric_id <= fab;
      req_ch.node_id <= node;
      req_ch.is_control <= ctl;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(kind, fab, node, ctl);
      sent_words++;
   endtask

   task automatic pause_sender();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sender pause until every expected word has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Node ids come from a small pool shared by all fabrics so that hits, evictions and
   // removals of present nodes are common; now and then a full random id.
   function automatic logic [63:0] pick_node();
      if ($urandom_range(9) == 0) return {$urandom, $urandom};
      return 64'd1 + 64'($urandom_range(21));
   endfunction

   function automatic logic [7:0] pick_fabric();
      if ($urandom_range(19) == 0) return 8'($urandom_range(255));
      return 8'd1 + 8'($urandom_range(9));
   endfunction

   task automatic random_word();
      int roll;
      logic [1:0] kind;
      roll = $urandom_range(99);
      if (roll < 62) kind = KIND_FIND_OR_ADD;
      else if (roll < 87) kind = KIND_REMOVE_PEER;
      else if (roll < 96) kind = KIND_REMOVE_FABRIC;
      else kind = KIND_RESERVED;
      send_word(kind, pick_fabric(),
                ($urandom_range(49) == 0) ? 64'd0 : pick_node(),
                $urandom_range(3) == 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero ids, the reserved kind and misses on an empty table.
      send_word(KIND_FIND_OR_ADD, 8'd0, 64'd5, 1'b0);
      send_word(KIND_FIND_OR_ADD, 8'd3, 64'd0, 1'b1);
      send_word(KIND_RESERVED, 8'd3, 64'd5, 1'b0);
      send_word(KIND_REMOVE_PEER, 8'd3, 64'd5, 1'b0);
      send_word(KIND_REMOVE_FABRIC, 8'd3, 64'd0, 1'b0);
      send_word(KIND_REMOVE_FABRIC, 8'd0, 64'd0, 1'b0);
      // Fresh slots up to a full table, with extreme ids, then one more.
      for (int f = 0; f < MAX_FABRIC_SLOTS; f++)
         send_word(KIND_FIND_OR_ADD, (f == 0) ? 8'd255 : f[7:0],
                   (f == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd100 + 64'(f), f[0]);
      send_word(KIND_FIND_OR_ADD, 8'd200, 64'd1, 1'b0);
      // Control list past full evicts; a hit moves to the front.
      for (int n = 0; n < MAX_CONTROL_PEERS + 2; n++)
         send_word(KIND_FIND_OR_ADD, 8'd2, 64'd10 + 64'(n), 1'b1);
      send_word(KIND_FIND_OR_ADD, 8'd2, 64'd12, 1'b1);
      // Removing the last peer frees a slot and the last slot moves down.
      send_word(KIND_REMOVE_PEER, 8'd255, 64'd100, 1'b0);
      send_word(KIND_REMOVE_FABRIC, 8'd1, 64'd0, 1'b0);
      drain();

      // Data list overflow across the full depth.
      for (int n = 0; n < MAX_DATA_PEERS + 3; n++)
         send_word(KIND_FIND_OR_ADD, 8'd4, 64'd1 + 64'($urandom_range(40)), 1'b0);
      drain();

      // Receiver holds off while the sender keeps offering, so the block fills
      // up and stalls its input.
      hold_rsp = 400;
      for (int i = 0; i < 20; i++) random_word();
      drain();

      // Random part: a stretch with no idling first, then idling switched on, off and on again.
      for (int i = 0; i < 400; i++) begin
         if (i == 100) idle_on = 1'b1;
         if (i == 300) idle_on = 1'b0;
         if (i == 360) idle_on = 1'b1;
         if (i % 97 == 96) drain();
         random_word();
      end
      pause_sender();
      drain();
      repeat (gplru_tb_pkg::RSP_LATENCY) @(posedge clock);

      $display("Sent %0d request words, checked %0d responses (%0d hits, %0d evictions),",
               sent_words, sb.checked, sb.hits, sb.evictions);
      $display("with %0d fabric slots in use at the end and %0d mismatches.",
               sb.used_slots(), sb.errors);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
